/* hdl/rrc_pkg.sv */
// Shared package for the reference-counted resource cache.
// Holds request and status codes, the table entry layout and the
// controller/datapath command and status structs. No dependencies.
package rrc_pkg;

	localparam int DEF_TABLE_SLOTS = 256;
	localparam int KEY_W = 15;
	localparam int CNT_W = 8;

	// Request codes as seen on req_type.
	localparam logic [1:0] REQ_ACQUIRE = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_HIT        = 3'd0;
	localparam logic [2:0] ST_LOADED     = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_ALLOC_FAIL = 3'd3;
	localparam logic [2:0] ST_HELD       = 3'd4;
	localparam logic [2:0] ST_FREED      = 3'd5;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd6;
	localparam logic [2:0] ST_CLEARED    = 3'd7;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] refs;
	} entry_t;

	// Operation the controller asks the datapath to perform this cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN,
		OP_MISS,
		OP_REL_RD,
		OP_REL_WR,
		OP_MISC,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_more;
		logic out_free;
	} sts_t;

endpackage

/* hdl/rrc_ctrl.sv */
// Controller state machine of the reference-counted resource cache.
// Sequences acquire, release and clear requests; depends on rrc_pkg.
module rrc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    req_type,
	input  rrc_pkg::sts_t sts,
	output rrc_pkg::cmd_t cmd
);
	import rrc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_MISS   = 7'b0000100,
		S_REL_RD = 7'b0001000,
		S_REL_WR = 7'b0010000,
		S_MISC   = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					case (req_type)
						REQ_ACQUIRE: state_d = S_SCAN;
						REQ_RELEASE: state_d = S_REL_RD;
						default:     state_d = S_MISC;
					endcase
				end
			end
			S_SCAN: begin
				cmd.op = OP_SCAN;
				if (sts.hit) begin
					state_d = S_EMIT;
				end else if (!sts.scan_more) begin
					state_d = S_MISS;
				end
			end
			S_MISS: begin
				cmd.op  = OP_MISS;
				state_d = S_EMIT;
			end
			S_REL_RD: begin
				cmd.op  = OP_REL_RD;
				state_d = S_REL_WR;
			end
			S_REL_WR: begin
				cmd.op  = OP_REL_WR;
				state_d = S_EMIT;
			end
			S_MISC: begin
				cmd.op  = OP_MISC;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.op = OP_EMIT;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/rrc_dpath.sv */
// Datapath of the reference-counted resource cache: slot table memory,
// scan counter, high-water count and the output register. Depends on rrc_pkg.
module rrc_dpath #(
	parameter int TableSlots = rrc_pkg::DEF_TABLE_SLOTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rrc_pkg::cmd_t             cmd,
	output rrc_pkg::sts_t             sts,
	input  logic [1:0]                req_type,
	input  logic [rrc_pkg::KEY_W-1:0] res_id,
	input  logic [7:0]                slot_index,
	input  logic                      alloc_ok,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic [7:0]                slot_out,
	output logic [rrc_pkg::CNT_W-1:0] ref_count
);
	import rrc_pkg::*;

	localparam int IDX_W  = $clog2(TableSlots);
	localparam int USED_W = $clog2(TableSlots + 1);
	localparam int CMP_W  = (USED_W > 8) ? USED_W : 8;

	entry_t mem [TableSlots];
	entry_t rd_q;

	logic [1:0]       req_q;
	logic [KEY_W-1:0] id_q;
	logic [7:0]       slot_q;
	logic             ok_q;

	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] ctr_q;
	logic              pipe_v_q;
	logic [IDX_W-1:0]  pipe_idx_q;
	logic [IDX_W-1:0]  chosen_q;
	logic              have_empty_q;

	logic [2:0]       res_status_q;
	logic [7:0]       res_slot_q;
	logic [CNT_W-1:0] res_refs_q;
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [7:0]       slot_out_q;
	logic [CNT_W-1:0] ref_count_q;

	logic             scan_more;
	logic             hit;
	logic             slot_ok;
	logic             full;
	logic             out_free;
	logic [IDX_W-1:0] miss_slot;
	logic [CNT_W-1:0] hit_refs;
	logic [CNT_W-1:0] rel_refs;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             res_set;
	logic [2:0]       res_status;
	logic [7:0]       res_slot;
	logic [CNT_W-1:0] res_refs;

	assign scan_more = (ctr_q < used_q);
	assign hit       = pipe_v_q && rd_q.valid && (rd_q.key == id_q);
	assign slot_ok   = (CMP_W'(slot_q) < CMP_W'(used_q));
	assign full      = (used_q == USED_W'(TableSlots));
	assign out_free  = !out_valid_q || !out_stall;
	assign miss_slot = have_empty_q ? chosen_q : used_q[IDX_W-1:0];
	assign hit_refs  = rd_q.refs + CNT_W'(1);
	assign rel_refs  = rd_q.refs - CNT_W'(1);

	assign sts.hit       = hit;
	assign sts.scan_more = scan_more;
	assign sts.out_free  = out_free;

	// Read port: the scan walks the counter, a release looks up its slot.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ctr_q[IDX_W-1:0];
		case (cmd.op)
			OP_SCAN: begin
				rd_en = scan_more;
			end
			OP_REL_RD: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(slot_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Write port and result selection.
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = pipe_idx_q;
		wr_data    = rd_q;
		res_set    = 1'b0;
		res_status = ST_NOT_FOUND;
		res_slot   = 8'd0;
		res_refs   = '0;
		case (cmd.op)
			OP_SCAN: begin
				if (hit) begin
					wr_en      = 1'b1;
					wr_data    = '{valid: 1'b1, key: rd_q.key, refs: hit_refs};
					res_set    = 1'b1;
					res_status = ST_HIT;
					res_slot   = 8'(pipe_idx_q);
					res_refs   = hit_refs;
				end
			end
			OP_MISS: begin
				res_set = 1'b1;
				if (!have_empty_q && full) begin
					res_status = ST_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = miss_slot;
					res_slot = 8'(miss_slot);
					if (ok_q) begin
						wr_data    = '{valid: 1'b1, key: id_q, refs: CNT_W'(1)};
						res_status = ST_LOADED;
						res_refs   = CNT_W'(1);
					end else begin
						wr_data    = '{valid: 1'b0, key: '0, refs: '0};
						res_status = ST_ALLOC_FAIL;
					end
				end
			end
			OP_REL_WR: begin
				res_set  = 1'b1;
				res_slot = slot_q;
				if (slot_ok && rd_q.valid) begin
					wr_en   = 1'b1;
					wr_addr = IDX_W'(slot_q);
					if (rel_refs != '0) begin
						wr_data    = '{valid: 1'b1, key: rd_q.key, refs: rel_refs};
						res_status = ST_HELD;
						res_refs   = rel_refs;
					end else begin
						wr_data    = '{valid: 1'b0, key: rd_q.key, refs: '0};
						res_status = ST_FREED;
					end
				end
			end
			OP_MISC: begin
				res_set = 1'b1;
				if (req_q == REQ_CLEAR) begin
					res_status = ST_CLEARED;
				end
			end
			default: begin
				res_set = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			req_q  <= req_type;
			id_q   <= res_id;
			slot_q <= slot_index;
			ok_q   <= alloc_ok;
		end
		if (cmd.op == OP_SCAN) begin
			if (scan_more) begin
				pipe_idx_q <= ctr_q[IDX_W-1:0];
			end
			if (pipe_v_q && !rd_q.valid) begin
				chosen_q <= pipe_idx_q;
			end
		end
		if (res_set) begin
			res_status_q <= res_status;
			res_slot_q   <= res_slot;
			res_refs_q   <= res_refs;
		end
		if (cmd.op == OP_EMIT && out_free) begin
			status_q    <= res_status_q;
			slot_out_q  <= res_slot_q;
			ref_count_q <= res_refs_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			ctr_q        <= '0;
			pipe_v_q     <= 1'b0;
			have_empty_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					ctr_q        <= '0;
					pipe_v_q     <= 1'b0;
					have_empty_q <= 1'b0;
				end
				OP_SCAN: begin
					pipe_v_q <= scan_more;
					if (scan_more) begin
						ctr_q <= ctr_q + USED_W'(1);
					end
					if (pipe_v_q && !rd_q.valid) begin
						have_empty_q <= 1'b1;
					end
				end
				OP_MISS: begin
					if (!have_empty_q && !full) begin
						used_q <= used_q + USED_W'(1);
					end
				end
				OP_MISC: begin
					ctr_q        <= '0;
					have_empty_q <= 1'b0;
					if (req_q == REQ_CLEAR) begin
						used_q <= '0;
					end
				end
				default: begin
					pipe_v_q <= pipe_v_q;
				end
			endcase
			if (cmd.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot_out  = slot_out_q;
	assign ref_count = ref_count_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TableSlots))
		else $error("high-water count exceeds table size");

	a_ctr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_q <= used_q)
		else $error("scan counter ran past the used slots");

	a_chosen_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MISS && have_empty_q) |-> (USED_W'(chosen_q) < used_q))
		else $error("reused slot lies outside the used slots");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MISC && req_q == REQ_CLEAR) |=> (used_q == '0))
		else $error("clear did not empty the table");
`endif

endmodule

/* hdl/refcounted_resource_cache.sv */
// Top level of the reference-counted resource cache: joins the controller
// and the datapath. Depends on rrc_pkg, rrc_ctrl and rrc_dpath.
//
// Channel  Direction  Handshake            Beat contents
// -------  ---------  -------------------  -------------------------------------
// in       input      in_valid / in_stall  req_type, res_id, slot_index, alloc_ok
// out      output     out_valid/out_stall  status, slot_out, ref_count
//
// One request is worked at a time. An acquire scans the used slots through
// the table memory's single read port, one slot per cycle, until it hits or
// has read every used slot. A release reads its slot and then writes it back;
// a clear touches no table entry.
// Reset clears only the control state and the high-water count; the table
// needs no clearing pass since no entry at or above the high-water count is used.
// A new beat is taken as soon as the previous result sits in the output
// register, even while out_stall holds that result back.
module refcounted_resource_cache #(
	parameter int TABLE_SLOTS = rrc_pkg::DEF_TABLE_SLOTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [rrc_pkg::KEY_W-1:0] res_id,
	input  logic [7:0]                slot_index,
	input  logic                      alloc_ok,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic [7:0]                slot_out,
	output logic [rrc_pkg::CNT_W-1:0] ref_count
);
	import rrc_pkg::*;

	// Command from the controller and status back from the datapath.
	cmd_t cmd;
	sts_t sts;

	rrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrc_dpath #(
		.TableSlots (TABLE_SLOTS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_type),
		.res_id     (res_id),
		.slot_index (slot_index),
		.alloc_ok   (alloc_ok),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot_out   (slot_out),
		.ref_count  (ref_count)
	);

endmodule
